// ===== rtl/calo_trigger_bank_deframer_unit_macros.svh =====
// assertion macros for the trigger bank deframer
// used by the top level only, no other dependencies
`ifndef CALO_TRIGGER_BANK_DEFRAMER_UNIT_MACROS_SVH
`define CALO_TRIGGER_BANK_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CTBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctbd same cycle check failed");

// next-cycle implication, disabled during reset
`define CTBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctbd next cycle check failed");

`endif

// ===== rtl/ctbd_pkg.sv =====
// shared types and helpers for the trigger bank deframer
// no dependencies
`timescale 1ns / 1ps

package ctbd_pkg;

   localparam int WORD_W   = 32;
   localparam int CELL_W   = 16;
   localparam int CODE_W   = 9;
   localparam int CHAN_W   = 5;
   localparam int ADC_W    = 8;
   localparam int SOURCE_W = 16;
   localparam int COUNT_W  = 3;   // up to four records per word

   // one word's worth of records handed from front to back
   typedef struct packed {
      logic                per_card;
      logic [WORD_W-1:0]   word;
      logic [CODE_W-1:0]   code;
      logic [SOURCE_W-1:0] source;
      logic [WORD_W-1:0]   pattern;
      logic [1:0]          off_mask;  // bit 1: upper cell byte, bit 0: lower
      logic [COUNT_W-1:0]  count;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   // index of the lowest set bit, zero for an empty pattern
   function automatic logic [CHAN_W-1:0] lowest_set(input logic [WORD_W-1:0] p);
      logic [CHAN_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (p[i]) begin
            idx = CHAN_W'(i);
         end
      end
      return idx;
   endfunction

   // clear the lowest set bit
   function automatic logic [WORD_W-1:0] clear_lowest(input logic [WORD_W-1:0] p);
      return p & (p - WORD_W'(1));
   endfunction

endpackage

// ===== rtl/ctbd_front.sv =====
// front end: bank framing state, card header decode, job building
// depends on ctbd_pkg
`timescale 1ns / 1ps

module ctbd_front
   import ctbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  logic                accept,
   input  logic [WORD_W-1:0]   data_word,
   input  logic                first_word,
   input  logic                last_word,
   input  logic [1:0]          bank_version,
   input  logic                magic_ok,
   input  logic [SOURCE_W-1:0] source_tag,
   output push_type            push_out
);

   typedef enum logic [2:0] {
      PH_START,
      PH_IDLE,
      PH_OFFLINE,
      PH_HEADER,
      PH_PATTERN,
      PH_DATA,
      PH_SKIP
   } phase_type;

   phase_type           phase_ff, phase_in, phase_cur;
   logic [SOURCE_W-1:0] source_ff, source_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [WORD_W-1:0]   pattern_ff, pattern_in;
   logic [4:0]          skip_ff, skip_in;
   logic                extra_header_ff, extra_header_in;

   logic [WORD_W-1:0]   pat1, pat2, pat3, pat4;
   logic [6:0]          adc_sum;
   logic [4:0]          hdr_skip;
   logic [4:0]          skip_dec;
   logic                consumed;
   logic                b1_nz, b0_nz;

   // data phase is never entered on a first word, so the held pattern is the live one
   assign pat1     = clear_lowest(pattern_ff);
   assign pat2     = clear_lowest(pat1);
   assign pat3     = clear_lowest(pat2);
   assign pat4     = clear_lowest(pat3);
   assign adc_sum  = {1'b0, data_word[12:7]} + 7'd3;
   assign hdr_skip = adc_sum[6:2];
   assign b1_nz    = (data_word[15:8] != '0);
   assign b0_nz    = (data_word[7:0] != '0);

   always_comb begin
      phase_cur       = phase_ff;
      source_in       = source_ff;
      code_in         = code_ff;
      pattern_in      = pattern_ff;
      skip_in         = skip_ff;
      extra_header_in = csr_write_enable ? csr_write_data : extra_header_ff;
      consumed        = 1'b0;
      skip_dec        = '0;
      push_out        = '0;

      // bank start resets the card context
      if (first_word) begin
         source_in  = source_tag;
         code_in    = '0;
         pattern_in = '0;
         skip_in    = '0;
         consumed   = extra_header_ff;
         if (!magic_ok || bank_version == 2'd3) begin
            phase_cur = PH_IDLE;
         end else if (bank_version < 2'd2) begin
            phase_cur = PH_OFFLINE;
         end else begin
            phase_cur = PH_HEADER;
         end
      end
      phase_in = phase_cur;

      push_out.job.word     = data_word;
      push_out.job.source   = source_in;
      push_out.job.code     = code_in;
      push_out.job.pattern  = pattern_in;

      if (!consumed) begin
         unique case (phase_cur)
            PH_OFFLINE: begin
               push_out.job.per_card = 1'b0;
               push_out.job.off_mask = {b1_nz, b0_nz};
               push_out.job.count    = {2'b00, b1_nz} + {2'b00, b0_nz};
               push_out.job.code     = '0;
               push_out.push         = b1_nz || b0_nz;
            end
            PH_HEADER: begin
               code_in    = data_word[22:14];
               skip_in    = hdr_skip;
               pattern_in = '0;
               if (data_word[5:0] != '0) begin
                  phase_in = PH_PATTERN;
               end else begin
                  phase_in = (hdr_skip == '0) ? PH_HEADER : PH_SKIP;
               end
            end
            PH_PATTERN: begin
               pattern_in = data_word;
               phase_in   = PH_DATA;
            end
            PH_DATA: begin
               // up to four set bits consumed per data word
               push_out.job.per_card = 1'b1;
               push_out.job.count    = {2'b00, pattern_ff != '0} + {2'b00, pat1 != '0}
                                     + {2'b00, pat2 != '0} + {2'b00, pat3 != '0};
               push_out.push         = (pattern_ff != '0);
               pattern_in            = pat4;
               if (pat4 == '0) begin
                  phase_in = (skip_ff == '0) ? PH_HEADER : PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_dec = (skip_ff != '0) ? skip_ff - 5'd1 : skip_ff;
               skip_in  = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_START, PH_IDLE: begin
            end
            default: begin
            end
         endcase
      end

      if (last_word) begin
         phase_in = PH_START;
      end

      if (!accept) begin
         phase_in      = phase_ff;
         source_in     = source_ff;
         code_in       = code_ff;
         pattern_in    = pattern_ff;
         skip_in       = skip_ff;
         push_out.push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         source_ff       <= '0;
         code_ff         <= '0;
         pattern_ff      <= '0;
         skip_ff         <= '0;
         extra_header_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         source_ff       <= source_in;
         code_ff         <= code_in;
         pattern_ff      <= pattern_in;
         skip_ff         <= skip_in;
         extra_header_ff <= extra_header_in;
      end
   end

endmodule

// ===== rtl/ctbd_queue.sv =====
// two-entry job queue between front and back
// depends on ctbd_pkg
`timescale 1ns / 1ps

module ctbd_queue
   import ctbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output job_type  head
);

   job_type    entry0_ff, entry0_in;
   job_type    entry1_ff, entry1_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = rd_ptr_ff ? entry1_ff : entry0_ff;

   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         if (wr_ptr_ff) begin
            entry1_in = push_in.job;
         end else begin
            entry0_in = push_in.job;
         end
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push_in.push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/ctbd_back.sv =====
// back end: walks one job a record per cycle into the output register
// unless rsp_stall holds it; depends on ctbd_pkg
`timescale 1ns / 1ps

module ctbd_back
   import ctbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  job_type             head,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_per_card,
   output logic [CELL_W-1:0]   rsp_cell_id,
   output logic [CODE_W-1:0]   rsp_card_code,
   output logic [CHAN_W-1:0]   rsp_channel,
   output logic [ADC_W-1:0]    rsp_adc_value,
   output logic [SOURCE_W-1:0] rsp_source_out,
   output logic                rsp_run_end
);

   job_type             job_ff, job_in;
   logic                active_ff, active_in;
   logic [1:0]          byte_ff, byte_in;
   logic                valid_ff, valid_in;
   logic                per_card_ff, per_card_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [ADC_W-1:0]    adc_ff, adc_in;
   logic [SOURCE_W-1:0] source_ff, source_in;
   logic                run_end_ff, run_end_in;

   logic                out_free, fire, finish;
   logic [ADC_W-1:0]    card_byte;

   assign out_free = !valid_ff || !rsp_stall;
   assign fire     = active_ff && out_free;
   assign finish   = fire && (job_ff.count == COUNT_W'(1));
   assign pop      = head_valid && (!active_ff || finish);

   always_comb begin
      case (byte_ff)
         2'd0:    card_byte = job_ff.word[7:0];
         2'd1:    card_byte = job_ff.word[15:8];
         2'd2:    card_byte = job_ff.word[23:16];
         default: card_byte = job_ff.word[31:24];
      endcase
   end

   always_comb begin
      job_in      = job_ff;
      active_in   = active_ff;
      byte_in     = byte_ff;
      valid_in    = valid_ff;
      per_card_in = per_card_ff;
      cell_in     = cell_ff;
      code_in     = code_ff;
      chan_in     = chan_ff;
      adc_in      = adc_ff;
      source_in   = source_ff;
      run_end_in  = run_end_ff;

      if (fire) begin
         valid_in    = 1'b1;
         per_card_in = job_ff.per_card;
         source_in   = job_ff.source;
         run_end_in  = (job_ff.count == COUNT_W'(1));
         job_in.count = job_ff.count - COUNT_W'(1);
         if (job_ff.per_card) begin
            cell_in        = '0;
            code_in        = job_ff.code;
            chan_in        = lowest_set(job_ff.pattern);
            adc_in         = card_byte;
            job_in.pattern = clear_lowest(job_ff.pattern);
            byte_in        = byte_ff + 2'd1;
         end else begin
            code_in = '0;
            chan_in = '0;
            if (job_ff.off_mask[1]) begin
               cell_in         = job_ff.word[31:16];
               adc_in          = job_ff.word[15:8];
               job_in.off_mask = {1'b0, job_ff.off_mask[0]};
            end else begin
               cell_in         = job_ff.word[31:16] + CELL_W'(1);
               adc_in          = job_ff.word[7:0];
               job_in.off_mask = 2'b00;
            end
         end
      end else if (out_free) begin
         valid_in = 1'b0;
      end

      if (pop) begin
         job_in    = head;
         active_in = 1'b1;
         byte_in   = '0;
      end else if (finish) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      byte_ff     <= byte_in;
      per_card_ff <= per_card_in;
      cell_ff     <= cell_in;
      code_ff     <= code_in;
      chan_ff     <= chan_in;
      adc_ff      <= adc_in;
      source_ff   <= source_in;
      run_end_ff  <= run_end_in;
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_per_card   = per_card_ff;
   assign rsp_cell_id    = cell_ff;
   assign rsp_card_code  = code_ff;
   assign rsp_channel    = chan_ff;
   assign rsp_adc_value  = adc_ff;
   assign rsp_source_out = source_ff;
   assign rsp_run_end    = run_end_ff;

endmodule

// ===== rtl/calo_trigger_bank_deframer_unit.sv =====
// top level of the trigger bank deframer: front, job queue, back
// depends on ctbd_pkg, ctbd_front, ctbd_queue, ctbd_back and the macros header
`timescale 1ns / 1ps
`include "calo_trigger_bank_deframer_unit_macros.svh"

//  channel   direction  handshake           word
//  req_      in         req_valid/req_stall one 32-bit bank word plus framing flags
//  rsp_      out        rsp_valid/rsp_stall one trigger record
//  csr_      in         csr_write_enable    extra_header bit, no read-back
//
//  a bank word is taken whenever the queue is not full; the back end puts out one
//  record per cycle while rsp_stall is low, so a data word of a card gives up to four
//  records, an offline word up to two, header/pattern/skip words none on the output side
//  the two-entry job queue lets the front keep taking words while records drain
//  synchronous reset clears framing state, queue and output valid; no memory sweep
//  req_stall is the queue full flag; rsp_stall holds the output register

module calo_trigger_bank_deframer_unit
   import ctbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   // input words
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic                req_first_word,
   input  logic                req_last_word,
   input  logic [1:0]          req_bank_version,
   input  logic                req_magic_ok,
   input  logic [SOURCE_W-1:0] req_source_tag,
   // result records
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_per_card,
   output logic [CELL_W-1:0]   rsp_cell_id,
   output logic [CODE_W-1:0]   rsp_card_code,
   output logic [CHAN_W-1:0]   rsp_channel,
   output logic [ADC_W-1:0]    rsp_adc_value,
   output logic [SOURCE_W-1:0] rsp_source_out,
   output logic                rsp_run_end
);

   // word accepted when valid and not stalled
   logic     req_accept;
   push_type front_push;
   logic     q_full;
   logic     q_head_valid;
   job_type  q_head;
   logic     q_pop;

   assign req_accept = req_valid && !req_stall;
   // only a full queue holds off the source
   assign req_stall  = q_full;

   // framing state machine, turns each word into at most one job
   ctbd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (req_accept),
      .data_word        (req_data_word),
      .first_word       (req_first_word),
      .last_word        (req_last_word),
      .bank_version     (req_bank_version),
      .magic_ok         (req_magic_ok),
      .source_tag       (req_source_tag),
      .push_out         (front_push)
   );

   // decoupling queue
   ctbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (front_push),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // record generator with output register
   ctbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_per_card   (rsp_per_card),
      .rsp_cell_id    (rsp_cell_id),
      .rsp_card_code  (rsp_card_code),
      .rsp_channel    (rsp_channel),
      .rsp_adc_value  (rsp_adc_value),
      .rsp_source_out (rsp_source_out),
      .rsp_run_end    (rsp_run_end)
   );

   // checks
   `CTBD_ASSERT_NOW(a_pop_has_data, clock, reset, q_pop, q_head_valid)
   `CTBD_ASSERT_NEXT(a_push_lands, clock, reset, front_push.push && !q_pop, q_head_valid)
   `CTBD_ASSERT_NOW(a_offline_clean, clock, reset, rsp_valid && !rsp_per_card, (rsp_card_code == '0) && (rsp_channel == '0) && (rsp_adc_value != '0))
   `CTBD_ASSERT_NOW(a_card_clean, clock, reset, rsp_valid && rsp_per_card, rsp_cell_id == '0)

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for calo_trigger_bank_deframer_unit
// depends on ctbd_pkg and the rtl of the deframer, nothing else
`timescale 1ns / 1ps

module tb;
   import ctbd_pkg::*;

   // cycles allowed for words that give no record to leave the pipe
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_WAIT      = 13;
   localparam int RANDOM_WORDS  = 300;

   // framing states of the bank decoder
   typedef enum logic [2:0] {
      WAIT_BANK,
      DEAD_BANK,
      OFFLINE_CELLS,
      CARD_HEADER,
      CARD_PATTERN,
      CARD_DATA,
      CARD_SKIP
   } frame_phase_t;

   // one input word with its framing flags
   typedef struct packed {
      logic [WORD_W-1:0]   data;
      logic                is_first;
      logic                is_last;
      logic [1:0]          version;
      logic                magic;
      logic [SOURCE_W-1:0] source;
   } bank_word_t;

   // one trigger record as it leaves the block
   typedef struct packed {
      logic                per_card;
      logic [CELL_W-1:0]   cell_id;
      logic [CODE_W-1:0]   code;
      logic [CHAN_W-1:0]   chan;
      logic [ADC_W-1:0]    adc;
      logic [SOURCE_W-1:0] source;
      logic                run_end;
   } trig_record_t;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic                csr_write_data;
   logic                req_valid;
   logic                req_stall;
   logic [WORD_W-1:0]   req_data_word;
   logic                req_first_word;
   logic                req_last_word;
   logic [1:0]          req_bank_version;
   logic                req_magic_ok;
   logic [SOURCE_W-1:0] req_source_tag;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_per_card;
   logic [CELL_W-1:0]   rsp_cell_id;
   logic [CODE_W-1:0]   rsp_card_code;
   logic [CHAN_W-1:0]   rsp_channel;
   logic [ADC_W-1:0]    rsp_adc_value;
   logic [SOURCE_W-1:0] rsp_source_out;
   logic                rsp_run_end;

   // decoder state mirrored by the predictor
   frame_phase_t        frame_phase;
   logic                extra_header_cfg;
   logic [SOURCE_W-1:0] bank_source;
   logic [CODE_W-1:0]   card_code;
   logic [WORD_W-1:0]   pending_channels;
   logic [4:0]          skip_count;

   trig_record_t        expected_records[$];
   logic [WORD_W-1:0]   bank_body[$];

   int  fault_count;
   int  records_checked;
   int  words_sent;
   int  live_words;
   int  offline_banks;
   int  card_banks;
   int  dead_banks;
   int  cut_banks;
   int  header_writes;
   bit  sender_idles;
   bit  receiver_idles;

   calo_trigger_bank_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_bank_version (req_bank_version),
      .req_magic_ok     (req_magic_ok),
      .req_source_tag   (req_source_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_per_card     (rsp_per_card),
      .rsp_cell_id      (rsp_cell_id),
      .rsp_card_code    (rsp_card_code),
      .rsp_channel      (rsp_channel),
      .rsp_adc_value    (rsp_adc_value),
      .rsp_source_out   (rsp_source_out),
      .rsp_run_end      (rsp_run_end)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic void add_record(input logic per_card, input logic [CELL_W-1:0] cell_id,
                                      input logic [CODE_W-1:0] code,
                                      input logic [CHAN_W-1:0] chan,
                                      input logic [ADC_W-1:0] adc);
      trig_record_t rec;
      rec.per_card = per_card;
      rec.cell_id  = cell_id;
      rec.code     = code;
      rec.chan     = chan;
      rec.adc      = adc;
      rec.source   = bank_source;
      rec.run_end  = 1'b0;
      expected_records.push_back(rec);
   endfunction

   // works out the records that one accepted word gives
   task automatic predict_word(input bank_word_t w);
      logic         dropped;
      int           depth;
      logic [4:0]   ch;
      logic         found;
      trig_record_t tail;
      dropped = 1'b0;
      depth   = expected_records.size();
      if (w.is_first || (frame_phase != WAIT_BANK && frame_phase != DEAD_BANK))
         live_words++;

      // bank start samples the framing fields and drops the old bank
      if (w.is_first) begin
         bank_source      = w.source;
         card_code        = '0;
         pending_channels = '0;
         skip_count       = '0;
         if (!w.magic || w.version == 2'd3)
            frame_phase = DEAD_BANK;
         else if (w.version < 2'd2)
            frame_phase = OFFLINE_CELLS;
         else
            frame_phase = CARD_HEADER;
         dropped = extra_header_cfg;
      end

      if (!dropped) begin
         case (frame_phase)
            OFFLINE_CELLS: begin
               // upper cell with byte 1, next cell with byte 0, zero bytes vanish
               if (w.data[15:8] != '0)
                  add_record(1'b0, w.data[31:16], '0, '0, w.data[15:8]);
               if (w.data[7:0] != '0)
                  add_record(1'b0, w.data[31:16] + 16'd1, '0, '0, w.data[7:0]);
            end
            CARD_HEADER: begin
               card_code        = w.data[22:14];
               skip_count       = 5'((int'(w.data[12:7]) + 3) / 4);
               pending_channels = '0;
               if (w.data[5:0] != '0)
                  frame_phase = CARD_PATTERN;
               else
                  frame_phase = (skip_count == '0) ? CARD_HEADER : CARD_SKIP;
            end
            CARD_PATTERN: begin
               pending_channels = w.data;
               frame_phase      = CARD_DATA;
            end
            CARD_DATA: begin
               // bytes go to the set pattern bits, lowest bit first
               for (int b = 0; b < 4; b++) begin
                  if (pending_channels != '0) begin
                     found = 1'b0;
                     ch    = '0;
                     for (int i = 0; i < WORD_W; i++) begin
                        if (!found && pending_channels[i]) begin
                           ch    = 5'(i);
                           found = 1'b1;
                        end
                     end
                     add_record(1'b1, '0, card_code, ch, w.data[8*b +: 8]);
                     pending_channels[ch] = 1'b0;
                  end
               end
               if (pending_channels == '0)
                  frame_phase = (skip_count == '0) ? CARD_HEADER : CARD_SKIP;
            end
            CARD_SKIP: begin
               if (skip_count != '0)
                  skip_count = skip_count - 5'd1;
               if (skip_count == '0)
                  frame_phase = CARD_HEADER;
            end
            default: begin
            end
         endcase
      end

      if (w.is_last)
         frame_phase = WAIT_BANK;

      // last record of this word carries run_end
      if (expected_records.size() > depth) begin
         tail = expected_records.pop_back();
         tail.run_end = 1'b1;
         expected_records.push_back(tail);
      end
   endtask

   // ---------------------------------------------------------------
   // word driver and helpers
   // ---------------------------------------------------------------

   // drives one word, waits for the handshake, then predicts
   task automatic send_word(input bank_word_t w);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if ($urandom_range(0, 49) == 0)
         sender_idles = !sender_idles;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_word    <= w.data;
      req_first_word   <= w.is_first;
      req_last_word    <= w.is_last;
      req_bank_version <= w.version;
      req_magic_ok     <= w.magic;
      req_source_tag   <= w.source;
      do
         @(posedge clock);
      while (req_stall);
      predict_word(w);
      words_sent++;
   endtask

   // sends bank_body as one bank, with the extra header set a dropped header word goes in front
   task automatic send_bank(input logic [1:0] version, input logic magic,
                            input logic [SOURCE_W-1:0] tag, input logic close);
      bank_word_t w;
      if (extra_header_cfg)
         bank_body.push_front($urandom);
      foreach (bank_body[i]) begin
         w.data     = bank_body[i];
         w.is_first = (i == 0);
         w.is_last  = close && (i == bank_body.size() - 1);
         // framing fields only count on the first word, noise elsewhere
         w.version  = (i == 0) ? version : 2'($urandom_range(0, 3));
         w.magic    = (i == 0) ? magic : 1'($urandom_range(0, 1));
         w.source   = (i == 0) ? tag : 16'($urandom);
         send_word(w);
      end
      bank_body.delete();
   endtask

   // appends header, pattern, data and skipped adc words of one card
   task automatic add_card(input logic [WORD_W-1:0] hdr_base, input logic [5:0] len_trig,
                           input logic [5:0] len_adc, input logic [CODE_W-1:0] code,
                           input logic [WORD_W-1:0] pattern);
      logic [WORD_W-1:0] hdr;
      int                bits;
      hdr        = hdr_base;
      hdr[5:0]   = len_trig;
      hdr[12:7]  = len_adc;
      hdr[22:14] = code;
      bank_body.push_back(hdr);
      if (len_trig != '0) begin
         bank_body.push_back(pattern);
         bits = $countones(pattern);
         // an empty pattern still takes one data word
         repeat ((bits == 0) ? 1 : (bits + 3) / 4)
            bank_body.push_back($urandom);
      end
      repeat ((int'(len_adc) + 3) / 4)
         bank_body.push_back($urandom);
   endtask

   function automatic logic [WORD_W-1:0] random_pattern();
      logic [WORD_W-1:0] p;
      int                pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         p = '0;
      else if (pick == 1)
         p = '1;
      else if (pick < 5)
         p = $urandom;
      else begin
         p = '0;
         repeat ($urandom_range(1, 6))
            p[$urandom_range(0, WORD_W - 1)] = 1'b1;
      end
      return p;
   endfunction

   task automatic add_random_card();
      logic [5:0] len_trig;
      logic [5:0] len_adc;
      len_trig = ($urandom_range(0, 4) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
      // mostly short adc blocks, now and then any length up to the longest
      len_adc  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 8));
      add_card($urandom, len_trig, len_adc, 9'($urandom), random_pattern());
   endtask

   // lets every pending record out and the pipe run empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_extra_header(input logic value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      extra_header_cfg = value;
      header_writes++;
   endtask

   // ---------------------------------------------------------------
   // record checker and output stall
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fault_count++;
      end
   endfunction

   task automatic check_record();
      trig_record_t want;
      if (expected_records.size() == 0) begin
         $error("record with nothing pending: adc_value %0h cell_id %0h",
                rsp_adc_value, rsp_cell_id);
         fault_count++;
         return;
      end
      want = expected_records.pop_front();
      check_field("per_card", want.per_card, rsp_per_card);
      check_field("cell_id", want.cell_id, rsp_cell_id);
      check_field("card_code", want.code, rsp_card_code);
      check_field("channel", want.chan, rsp_channel);
      check_field("adc_value", want.adc, rsp_adc_value);
      check_field("source_out", want.source, rsp_source_out);
      check_field("run_end", want.run_end, rsp_run_end);
      records_checked++;
   endtask

   // samples at the edge, draws a stall after each taken record
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_record();
            hold = receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
            if ($urandom_range(0, 63) == 0)
               receiver_idles = !receiver_idles;
         end
         rsp_stall <= (hold != 0);
         if (hold != 0)
            hold--;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // cell pairs, id wrap, zero suppression of either byte
   task automatic test_offline_cells();
      bank_body.push_back(32'hFFFF_FFFF);
      bank_body.push_back(32'h1234_0000);
      bank_body.push_back(32'h0000_00A5);
      bank_body.push_back(32'h8000_7F00);
      send_bank(2'd0, 1'b1, 16'hFFFF, 1'b1);
      offline_banks++;
   endtask

   // bad magic, version 3 and a stray word between banks
   task automatic test_dead_banks();
      bank_word_t w;
      bank_body.push_back(32'h0102_0304);
      bank_body.push_back(32'hFFFF_FFFF);
      send_bank(2'd1, 1'b0, 16'h0000, 1'b1);
      bank_body.push_back(32'hA5A5_A5A5);
      bank_body.push_back(32'h5A5A_5A5A);
      send_bank(2'd3, 1'b1, 16'h1234, 1'b1);
      dead_banks += 2;
      w.data     = 32'h0000_0000;
      w.is_first = 1'b0;
      w.is_last  = 1'b0;
      w.version  = 2'd0;
      w.magic    = 1'b1;
      w.source   = 16'hFFFF;
      send_word(w);
   endtask

   // card with control bits set and adc skip, empty card, empty pattern
   task automatic test_card_frames();
      add_card('1, 6'd1, 6'd5, 9'h1FF, 32'h8000_0021);
      add_card('0, 6'd0, 6'd0, 9'h000, 32'h0);
      add_card($urandom, 6'd63, 6'd0, 9'h0AA, 32'h0);
      send_bank(2'd2, 1'b1, 16'h5A5A, 1'b1);
      card_banks++;
   endtask

   // new bank in the middle of a card, then a bank that ends mid card
   task automatic test_broken_frames();
      add_card($urandom, 6'd7, 6'd2, 9'h155, 32'h0000_0F0F);
      while (bank_body.size() > 2)
         void'(bank_body.pop_back());
      send_bank(2'd2, 1'b1, 16'hC3C3, 1'b0);
      add_card($urandom, 6'd9, 6'd0, 9'h0F0, 32'hFFFF_FFFF);
      while (bank_body.size() > 3)
         void'(bank_body.pop_back());
      send_bank(2'd2, 1'b1, 16'h3C3C, 1'b1);
      cut_banks += 2;
   endtask

   // leading detector header dropped from the bank
   task automatic test_extra_header();
      write_extra_header(1'b1);
      bank_body.push_back(32'h0001_0203);
      send_bank(2'd1, 1'b1, 16'h8001, 1'b1);
      offline_banks++;
   endtask

   // mostly well formed banks, some dead, cut or stray words
   task automatic test_random_traffic();
      int         target;
      int         pick;
      bank_word_t w;
      logic [WORD_W-1:0] cells;
      target = live_words + RANDOM_WORDS;
      while (live_words < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            repeat ($urandom_range(1, 3)) add_random_card();
            send_bank(2'd2, 1'b1, 16'($urandom), 1'b1);
            card_banks++;
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 6)) begin
               cells = $urandom;
               if ($urandom_range(0, 3) == 0) cells[15:8] = '0;
               if ($urandom_range(0, 3) == 0) cells[7:0] = '0;
               if ($urandom_range(0, 7) == 0) cells[31:16] = '1;
               bank_body.push_back(cells);
            end
            send_bank(2'($urandom_range(0, 1)), 1'b1, 16'($urandom), 1'b1);
            offline_banks++;
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) bank_body.push_back($urandom);
            if ($urandom_range(0, 1) == 0)
               send_bank(2'($urandom_range(0, 3)), 1'b0, 16'($urandom), 1'b1);
            else
               send_bank(2'd3, 1'b1, 16'($urandom), 1'b1);
            dead_banks++;
         end else if (pick < 92) begin
            // cut card bank, closed or left open for the next first word
            repeat ($urandom_range(1, 2)) add_random_card();
            while (bank_body.size() > 1 && $urandom_range(0, 2) != 0)
               void'(bank_body.pop_back());
            send_bank(2'd2, 1'b1, 16'($urandom), 1'($urandom_range(0, 1)));
            cut_banks++;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               w.data     = $urandom;
               w.is_first = 1'b0;
               w.is_last  = 1'($urandom_range(0, 1));
               w.version  = 2'($urandom_range(0, 3));
               w.magic    = 1'($urandom_range(0, 1));
               w.source   = 16'($urandom);
               send_word(w);
            end
         end
         // register changes between banks, and a full pause now and then
         if ($urandom_range(0, 24) == 0)
            write_extra_header(1'($urandom_range(0, 1)));
         else if ($urandom_range(0, 29) == 0)
            drain_results();
      end
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_valid        = 1'b0;
      req_data_word    = '0;
      req_first_word   = 1'b0;
      req_last_word    = 1'b0;
      req_bank_version = 2'd0;
      req_magic_ok     = 1'b0;
      req_source_tag   = '0;
      sender_idles     = 1'b1;
      receiver_idles   = 1'b1;
      fault_count      = 0;
      records_checked  = 0;
      words_sent       = 0;
      live_words       = 0;
      offline_banks    = 0;
      card_banks       = 0;
      dead_banks       = 0;
      cut_banks        = 0;
      header_writes    = 0;
      frame_phase      = WAIT_BANK;
      extra_header_cfg = 1'b0;
      bank_source      = '0;
      card_code        = '0;
      pending_channels = '0;
      skip_count       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // explicit write of the reset value before any traffic
      write_extra_header(1'b0);
      test_offline_cells();
      test_dead_banks();
      test_card_frames();
      test_broken_frames();
      test_extra_header();
      write_extra_header(1'b0);
      test_random_traffic();
      drain_results();

      $display("ran %0d words: %0d offline, %0d card, %0d dead and %0d cut banks",
               words_sent, offline_banks, card_banks, dead_banks, cut_banks);
      $display("checked %0d records over %0d extra header writes",
               records_checked, header_writes);
      if (fault_count == 0 && expected_records.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
